FILE: rtl/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = 64;
  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = 4;
  localparam int CFG_LEN_W  = 5;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_CARE   = 2'd2,
    REG_LEN    = 2'd3
  } cfg_reg_t;

  // Per-cell view of the pattern: the byte this window slot must equal, and whether it is checked
  typedef struct packed {
    logic [BYTE_W-1:0] pat;
    logic              care;
  } cell_cfg_t;

endpackage

FILE: rtl/wbps_cell.sv
`timescale 1ns / 1ps

// One window slot: holds a byte and its valid bit, passes both on at each shift.
module wbps_cell import wbps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  logic              flush,
  input  logic [BYTE_W-1:0] din,
  input  logic              vin,
  input  cell_cfg_t         cfg,
  output logic [BYTE_W-1:0] dout,
  output logic              vout,
  output logic              hit_ok
);

  logic [BYTE_W-1:0] data;
  logic              vld;

  // compare against the byte arriving this cycle, i.e. the post-shift content
  assign hit_ok = !cfg.care || (din == cfg.pat);
  assign dout   = data;
  assign vout   = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift_en) begin
      vld <= flush ? 1'b0 : vin;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= din;
    end
  end

endmodule

FILE: rtl/wildcard_byte_pattern_scanner_core.sv
`timescale 1ns / 1ps

// Wildcard byte pattern scanner.
// Input stream (s_*): one buffer byte per transaction, s_tlast on the final
// byte of a buffer. Output stream (m_*): one transaction per match, carrying
// the buffer offset of the first byte of the match.
// Configuration: cfg_we/cfg_index/cfg_data write the pattern low and high
// words, the care mask and the pattern length; write only while idle.
// The window is a row of MAX_PATTERN cells that shift one byte per accepted
// transaction; all cells compare against the pattern in parallel.
// Throughput: one byte per cycle while the skid register is empty; s_tready
// drops while a stalled result sits there. A match is registered into the
// output register, or into the skid register if the receiver stalls.
// Reset clears the configuration, the window valid bits, the position
// counter and the output stage. When the receiver stalls, one further
// result is held in a skid register; s_tready drops only while that skid
// register is occupied, so the input side never waits on m_tready directly.
// The position counter saturates at all ones; no match is reported from
// the byte taken at that count onwards.
module wildcard_byte_pattern_scanner_core import wbps_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,   // end_of_buffer
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata    // [31:0] start_offset
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]     pat_lo;
  logic [CFG_W-1:0]     pat_hi;
  logic [PAT_BYTES-1:0] care_mask;
  logic [CFG_LEN_W-1:0] pat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo    <= '0;
      pat_hi    <= '0;
      care_mask <= '0;
      pat_len   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LO: pat_lo    <= cfg_data;
        REG_PAT_HI: pat_hi    <= cfg_data;
        REG_CARE:   care_mask <= cfg_data[PAT_BYTES-1:0];
        REG_LEN:    pat_len   <= cfg_data[CFG_LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Length clamped to the window size; an over-long pattern acts as full size
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] len_m1;
  logic [2*CFG_W-1:0] pat_flat;

  assign len_eff  = (int'(pat_len) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                  : LEN_W'(pat_len);
  assign len_m1   = len_eff - LEN_W'(1);
  assign pat_flat = {pat_hi, pat_lo};

  // ---------------------------------------------------------------------
  // Cell row. Cell 0 holds the newest byte. Window slot k is checked
  // against pattern byte len-1-k, so the pattern is laid onto the row
  // right-aligned to the newest byte.
  // ---------------------------------------------------------------------
  logic                            fire;
  logic [MAX_PATTERN-1:0]          cell_vin;
  logic [MAX_PATTERN-1:0]          cell_vout;
  logic [MAX_PATTERN-1:0]          cell_ok;
  logic [MAX_PATTERN-1:0]          cell_care;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cell_din;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cell_dout;
  cell_cfg_t [MAX_PATTERN-1:0]     cell_cfg;

  assign fire = s_tvalid && s_tready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [CFG_LEN_W-1:0] pidx;

    always_comb begin
      pidx = CFG_LEN_W'(len_eff) - CFG_LEN_W'(1) - CFG_LEN_W'(k);
      if (k < int'(len_eff)) begin
        cell_cfg[k].pat  = pat_flat[pidx[PAT_IDX_W-1:0]*BYTE_W +: BYTE_W];
        cell_cfg[k].care = care_mask[pidx[PAT_IDX_W-1:0]];
      end else begin
        cell_cfg[k].pat  = '0;
        cell_cfg[k].care = 1'b0;
      end
    end

    assign cell_care[k] = cell_cfg[k].care;

    if (k == 0) begin : g_head
      assign cell_din[k] = s_tdata;
      assign cell_vin[k] = 1'b1;
    end else begin : g_link
      assign cell_din[k] = cell_dout[k-1];
      assign cell_vin[k] = cell_vout[k-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (fire),
      .flush    (s_tlast),
      .din      (cell_din[k]),
      .vin      (cell_vin[k]),
      .cfg      (cell_cfg[k]),
      .dout     (cell_dout[k]),
      .vout     (cell_vout[k]),
      .hit_ok   (cell_ok[k])
    );
  end

  // ---------------------------------------------------------------------
  // Byte position within the buffer (saturating)
  // ---------------------------------------------------------------------
  logic [OFFSET_BITS-1:0] position;
  logic                   pos_sat;

  assign pos_sat = &position;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (fire) begin
      if (s_tlast) begin
        position <= '0;
      end else if (!pos_sat) begin
        position <= position + OFFSET_BITS'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Match decision and start offset
  // ---------------------------------------------------------------------
  logic                   hit;
  logic [OFFSET_BITS-1:0] start_pos;
  logic [OUT_W-1:0]       res_off;

  // window full enough: the slot holding the oldest pattern byte is valid
  assign hit = (len_eff != '0) && (|cell_care) && cell_vin[len_m1[IDX_W-1:0]]
               && (&cell_ok) && !pos_sat;

  assign start_pos = position - OFFSET_BITS'(len_m1);

  if (OFFSET_BITS >= OUT_W) begin : g_off_trunc
    assign res_off = start_pos[OUT_W-1:0];
  end else begin : g_off_ext
    assign res_off = {{(OUT_W-OFFSET_BITS){1'b0}}, start_pos};
  end

  // ---------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------
  logic             res_valid;
  logic             out_free;
  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;

  assign res_valid = fire && hit;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid   <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_data : res_off;
    end
    if (!out_free && res_valid) begin
      skid_data <= res_off;
    end
  end

endmodule

FILE: rtl/wbps_checker.sv
`timescale 1ns / 1ps

module wbps_checker import wbps_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // input only backs up if the output side was stalled in the previous cycle
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("s_tready low without an output stall");

  // a new result needs an input transaction just before
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without an accepted byte");

  // output stage empty straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (.*);
